FILE: rtl/assert_macros.svh
// assertion macros used by indexed_list_insert_delete_core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/ilid_pkg.sv
// types and constants for the positional list core
`timescale 1ns / 1ps

package ilid_pkg;

    typedef struct packed {
        logic [2:0]         func;
        logic signed [15:0] position;
        logic signed [31:0] value;
    } req_t;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [1:0]         status;
        logic [6:0]         count;
    } rsp_t;

    localparam logic [2:0] FN_READ = 3'd0;
    localparam logic [2:0] FN_HEAD = 3'd1;
    localparam logic [2:0] FN_TAIL = 3'd2;
    localparam logic [2:0] FN_AT   = 3'd3;
    localparam logic [2:0] FN_DEL  = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic signed [31:0] READ_MISS = -32'sd1;

    localparam logic [1:0] CMD_HOLD   = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_DELETE = 2'd2;
    localparam logic [1:0] CMD_READ   = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] value;
    } cell_cmd_t;

endpackage

FILE: rtl/ilid_cell.sv
// one list slot: holds an entry, shifts with its neighbors, forwards read data
`timescale 1ns / 1ps

module ilid_cell #(
    parameter int unsigned IDX_W = 6
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  ilid_pkg::cell_cmd_t     cmd,
    input  logic [IDX_W-1:0]        cmd_idx,
    input  logic [IDX_W-1:0]        idx,
    input  logic [31:0]             left_val,
    input  logic [31:0]             right_val,
    input  logic                    rd_in_valid,
    input  logic [31:0]             rd_in_data,
    output logic [31:0]             entry,
    output logic                    rd_valid,
    output logic [31:0]             rd_data
);

    logic [31:0] entry_reg, entry_next;
    logic        rd_valid_reg, rd_valid_next;
    logic [31:0] rd_data_reg, rd_data_next;
    logic        rd_hit;

    always_comb
    begin
        entry_next = entry_reg;
        case (cmd.op)
            ilid_pkg::CMD_INSERT:
            begin
                if (idx > cmd_idx)
                begin
                    entry_next = left_val;
                end
                else if (idx == cmd_idx)
                begin
                    entry_next = cmd.value;
                end
            end
            ilid_pkg::CMD_DELETE:
            begin
                if (idx >= cmd_idx)
                begin
                    entry_next = right_val;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    // read data walks one slot toward the head per cycle
    assign rd_hit        = (cmd.op == ilid_pkg::CMD_READ) && (idx == cmd_idx);
    assign rd_valid_next = rd_in_valid || rd_hit;
    assign rd_data_next  = rd_hit ? entry_reg : rd_in_data;

    always_ff @(posedge clk)
    begin
        entry_reg   <= entry_next;
        rd_data_reg <= rd_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= rd_valid_next;
        end
    end

    assign entry    = entry_reg;
    assign rd_valid = rd_valid_reg;
    assign rd_data  = rd_data_reg;

endmodule

FILE: rtl/indexed_list_insert_delete_core.sv
// positional list core: a row of CAPACITY slots that shift in place
// insert, delete, error: one item per cycle unless rsp_ready stalls; result registered next cycle
// read: the entry travels slot by slot from its slot to the head, then into the result register,
//   no new item taken meanwhile
// reset clears the count and the handshake state; slot contents stay undefined until written
`timescale 1ns / 1ps
`include "assert_macros.svh"

module indexed_list_insert_delete_core #(
    parameter int unsigned CAPACITY = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  ilid_pkg::req_t      req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output ilid_pkg::rsp_t      rsp
);

    localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    logic                state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                rsp_valid_reg, rsp_valid_next;
    ilid_pkg::rsp_t      rsp_reg, rsp_next;

    ilid_pkg::cell_cmd_t cmd;
    logic [IDX_W-1:0]    cmd_idx;

    logic [31:0]         cell_val [CAPACITY];
    logic                rd_vld   [CAPACITY];
    logic [31:0]         rd_dat   [CAPACITY];

    logic                accept;
    logic                pos_neg;
    logic [31:0]         pos_u;
    logic [31:0]         cnt_w;
    logic [31:0]         ins_pos;
    logic                rd_ok;
    logic                full;

    function automatic logic [6:0] cnt7(input logic [CNT_W-1:0] c);
        logic [CNT_W+6:0] w;
        w = {7'b0, c};
        return w[6:0];
    endfunction

    assign req_ready = (state_reg == S_IDLE) && (!rsp_valid_reg || rsp_ready);
    assign accept    = req_valid && req_ready;

    assign pos_neg = req.position[15];
    assign pos_u   = {16'b0, req.position};
    assign cnt_w   = 32'(cnt_reg);
    assign rd_ok   = !pos_neg && (pos_u < cnt_w);
    assign full    = (cnt_reg == CNT_W'(CAPACITY));

    always_comb
    begin
        case (req.func)
            ilid_pkg::FN_HEAD: ins_pos = '0;
            ilid_pkg::FN_TAIL: ins_pos = cnt_w;
            default:           ins_pos = pos_neg ? '0 : pos_u;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        cmd.op         = ilid_pkg::CMD_HOLD;
        cmd.value      = req.value;
        cmd_idx        = ins_pos[IDX_W-1:0];

        if (accept)
        begin
            rsp_next.read_value = '0;
            rsp_next.status     = ilid_pkg::ST_OK;
            case (req.func)
                ilid_pkg::FN_READ:
                begin
                    if (rd_ok)
                    begin
                        cmd.op     = ilid_pkg::CMD_READ;
                        cmd_idx    = pos_u[IDX_W-1:0];
                        state_next = S_READ;
                    end
                    else
                    begin
                        rsp_next.read_value = ilid_pkg::READ_MISS;
                        rsp_next.status     = ilid_pkg::ST_RANGE;
                        rsp_valid_next      = 1'b1;
                    end
                end
                ilid_pkg::FN_HEAD, ilid_pkg::FN_TAIL, ilid_pkg::FN_AT:
                begin
                    if (ins_pos > cnt_w)
                    begin
                        rsp_next.status = ilid_pkg::ST_RANGE;
                    end
                    else if (full)
                    begin
                        rsp_next.status = ilid_pkg::ST_FULL;
                    end
                    else
                    begin
                        cmd.op   = ilid_pkg::CMD_INSERT;
                        cnt_next = cnt_reg + 1'b1;
                    end
                    rsp_valid_next = 1'b1;
                end
                ilid_pkg::FN_DEL:
                begin
                    if (rd_ok)
                    begin
                        cmd.op   = ilid_pkg::CMD_DELETE;
                        cmd_idx  = pos_u[IDX_W-1:0];
                        cnt_next = cnt_reg - 1'b1;
                    end
                    else
                    begin
                        rsp_next.status = ilid_pkg::ST_RANGE;
                    end
                    rsp_valid_next = 1'b1;
                end
                default:
                begin
                    rsp_valid_next = 1'b1;
                end
            endcase
            rsp_next.count = cnt7(cnt_next);
        end

        // read data has reached the head slot; output register is empty here
        if ((state_reg == S_READ) && rd_vld[0])
        begin
            rsp_next.read_value = rd_dat[0];
            rsp_next.status     = ilid_pkg::ST_OK;
            rsp_next.count      = cnt7(cnt_reg);
            rsp_valid_next      = 1'b1;
            state_next          = S_IDLE;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic [31:0] left_val;
            logic [31:0] right_val;
            logic        rd_in_valid;
            logic [31:0] rd_in_data;

            if (gi == 0)
            begin : g_head
                assign left_val = '0;
            end
            else
            begin : g_mid_l
                assign left_val = cell_val[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_tail
                assign right_val   = '0;
                assign rd_in_valid = 1'b0;
                assign rd_in_data  = '0;
            end
            else
            begin : g_mid_r
                assign right_val   = cell_val[gi+1];
                assign rd_in_valid = rd_vld[gi+1];
                assign rd_in_data  = rd_dat[gi+1];
            end

            ilid_cell #(
                .IDX_W (IDX_W)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .cmd         (cmd),
                .cmd_idx     (cmd_idx),
                .idx         (IDX_W'(gi)),
                .left_val    (left_val),
                .right_val   (right_val),
                .rd_in_valid (rd_in_valid),
                .rd_in_data  (rd_in_data),
                .entry       (cell_val[gi]),
                .rd_valid    (rd_vld[gi]),
                .rd_data     (rd_dat[gi])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `ASSERT_ALWAYS(a_cnt_bound, cnt_reg <= CNT_W'(CAPACITY), "entry count above capacity")
    `ASSERT_IMPLY(a_rd_in_read, rd_vld[0], state_reg == S_READ, "read data outside a read")
    `ASSERT_IMPLY(a_full_cnt, rsp_valid_reg && (rsp_reg.status == ilid_pkg::ST_FULL),
        cnt_reg == CNT_W'(CAPACITY), "full status with room left")
    `ASSERT_NEXT(a_nonread_rsp, accept && (req.func != ilid_pkg::FN_READ), rsp_valid_reg,
        "no result after a non-read item")
    `ASSERT_NEXT(a_del_cnt, accept && (req.func == ilid_pkg::FN_DEL),
        cnt_reg <= $past(cnt_reg), "delete grew the list")

endmodule
